/* rtl/core/spq_pkg.sv */
// Shared types and sizes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

  localparam int DEPTH    = 64;
  localparam int ID_BITS  = 16;
  localparam int KEY_BITS = 32;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2
  } action_t;

  typedef struct packed {
    logic [ID_BITS-1:0]         vertex;
    logic signed [KEY_BITS-1:0] key;
  } entry_t;

  // Command broadcast to every cell; ins and rem are already qualified
  // by the input handshake, and ins also by the full check.
  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic [ID_BITS-1:0]         vertex;
    logic signed [KEY_BITS-1:0] key;
  } cmd_t;

endpackage

/* rtl/core/spq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast command and shifts with its neighbors. Depends on spq_pkg.
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t  cmd_i,
  input  logic           head_i,
  input  logic           occ_i,
  input  logic           prev_place_i,
  input  logic           prev_hit_i,
  input  spq_pkg::entry_t prev_entry_i,
  input  spq_pkg::entry_t next_entry_i,
  output logic           place_o,
  output logic           hit_o,
  output spq_pkg::entry_t entry_o,
  output spq_pkg::entry_t entry_nxt_o
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;
  logic            ge;
  logic            match;

  // The head only yields to a strictly smaller key; later slots yield on ties.
  assign ge      = head_i ? (entry_r.key > cmd_i.key) : (entry_r.key >= cmd_i.key);
  assign place_o = !occ_i || ge;
  assign match   = occ_i && (entry_r.vertex == cmd_i.vertex);
  assign hit_o   = prev_hit_i || match;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.ins) begin
      if (prev_place_i) begin
        entry_nxt = prev_entry_i;
      end else if (place_o) begin
        entry_nxt.vertex = cmd_i.vertex;
        entry_nxt.key    = cmd_i.key;
      end
    end else if (cmd_i.rem && hit_o) begin
      // close the gap left by the first match at or before this slot
      entry_nxt = next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o     = entry_r;
  assign entry_nxt_o = entry_nxt;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a chain of spq_cell slots, the
// fill count and the registered result word. Depends on spq_pkg, spq_cell.
//
// Holds up to DEPTH (vertex, signed key) entries in ascending key order in a
// chain of cells, one entry per cell. Every word taken (insert, remove by
// vertex id, peek) is applied in the cycle it is accepted, and its result
// word (head entry, empty flag, drop flag, entry count) appears in the output
// register on the next cycle; one word is accepted per cycle while the result
// side keeps up. Insert compares the key in every cell at once and shifts the
// tail one cell back; remove finds the first matching vertex through a
// found flag that ripples along the chain and shifts the tail one cell
// forward, which sets the longest path of the design. An insert into a full
// queue changes nothing and reports dropped. No clearing pass follows reset.
module sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic [spq_pkg::ID_BITS-1:0]         in_vertex_id,
  input  logic signed [spq_pkg::KEY_BITS-1:0] in_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spq_pkg::ID_BITS-1:0]         out_min_vertex,
  output logic signed [spq_pkg::KEY_BITS-1:0] out_min_key,
  output logic                                out_is_empty,
  output logic                                out_dropped,
  output logic [spq_pkg::CNT_BITS-1:0]        out_entry_count
);

  localparam int DEPTH    = spq_pkg::DEPTH;
  localparam int CNT_BITS = spq_pkg::CNT_BITS;

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                out_valid_r;
  logic [spq_pkg::ID_BITS-1:0]         min_vertex_r;
  logic signed [spq_pkg::KEY_BITS-1:0] min_key_r;
  logic                is_empty_r;
  logic                dropped_r;
  logic [CNT_BITS-1:0] entry_count_r;

  logic           accept;
  logic           full;
  logic           is_ins;
  logic           is_rem;
  spq_pkg::cmd_t  cmd;

  logic [DEPTH-1:0]           place;
  logic [DEPTH-1:0]           hit;
  logic [DEPTH-1:0]           occ;
  spq_pkg::entry_t [DEPTH-1:0] entry;
  spq_pkg::entry_t [DEPTH-1:0] entry_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign is_ins   = (in_action == spq_pkg::ACT_INSERT);
  assign is_rem   = (in_action == spq_pkg::ACT_REMOVE);

  always_comb begin
    cmd.ins    = accept && is_ins && !full;
    cmd.rem    = accept && is_rem;
    cmd.vertex = in_vertex_id;
    cmd.key    = in_key;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic            head;
      logic            prev_place;
      logic            prev_hit;
      spq_pkg::entry_t prev_entry;
      spq_pkg::entry_t next_entry;

      assign occ[gi] = (count_r > CNT_BITS'(gi));

      if (gi == 0) begin : g_first
        assign head       = 1'b1;
        assign prev_place = 1'b0;
        assign prev_hit   = 1'b0;
        assign prev_entry = '0;
      end else begin : g_rest
        assign head       = 1'b0;
        assign prev_place = place[gi-1];
        assign prev_hit   = hit[gi-1];
        assign prev_entry = entry[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign next_entry = '0;
      end else begin : g_mid
        assign next_entry = entry[gi+1];
      end

      spq_cell u_cell (
        .clk          (clk),
        .cmd_i        (cmd),
        .head_i       (head),
        .occ_i        (occ[gi]),
        .prev_place_i (prev_place),
        .prev_hit_i   (prev_hit),
        .prev_entry_i (prev_entry),
        .next_entry_i (next_entry),
        .place_o      (place[gi]),
        .hit_o        (hit[gi]),
        .entry_o      (entry[gi]),
        .entry_nxt_o  (entry_nxt[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.rem && hit[DEPTH-1]) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word reflects the head after this word's action
  always_ff @(posedge clk) begin
    if (accept) begin
      if (count_nxt == '0) begin
        min_vertex_r <= '0;
        min_key_r    <= '0;
      end else begin
        min_vertex_r <= entry_nxt[0].vertex;
        min_key_r    <= entry_nxt[0].key;
      end
      is_empty_r    <= (count_nxt == '0);
      dropped_r     <= is_ins && full;
      entry_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_vertex  = min_vertex_r;
  assign out_min_key     = min_key_r;
  assign out_is_empty    = is_empty_r;
  assign out_dropped     = dropped_r;
  assign out_entry_count = entry_count_r;

endmodule

/* tb/sv/sorted_priority_queue_check.sv */
// Checker for the sorted priority queue: watches both channels, predicts
// the head report of every accepted word and compares it with the block.
// Depends on spq_pkg.
`timescale 1ns / 100ps

module sorted_priority_queue_check
  import spq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [ID_BITS-1:0]          in_vertex_id,
  input  logic signed [KEY_BITS-1:0]  in_key,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [ID_BITS-1:0]          out_min_vertex,
  input  logic signed [KEY_BITS-1:0]  out_min_key,
  input  logic                        out_is_empty,
  input  logic                        out_dropped,
  input  logic [CNT_BITS-1:0]         out_entry_count,
  output int                          outstanding,
  output int                          fail_count
);

  typedef struct packed {
    logic [ID_BITS-1:0]         vertex;
    logic signed [KEY_BITS-1:0] key;
    logic                       is_empty;
    logic                       dropped;
    logic [CNT_BITS-1:0]        count;
  } head_report_t;

  entry_t       held [DEPTH];
  int           held_count = 0;
  head_report_t head_reports_q [$];
  int           mismatch_total = 0;

  assign fail_count = mismatch_total;

  initial outstanding = 0;

  // Apply one word to the shadow queue and return the head report after it.
  function automatic head_report_t queue_apply(input logic [1:0] act,
                                               input logic [ID_BITS-1:0] vid,
                                               input logic signed [KEY_BITS-1:0] key);
    head_report_t rpt;
    int           pos;
    int           i;
    bit           hit;
    rpt = '0;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        rpt.dropped = 1'b1;
      end else begin
        // Equal to the head goes behind it; elsewhere ahead of the first equal.
        if (held_count == 0) begin
          pos = 0;
        end else if ($signed(held[0].key) > $signed(key)) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < held_count && $signed(held[pos].key) < $signed(key)) pos++;
        end
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].vertex = vid;
        held[pos].key    = key;
        held_count++;
      end
    end else if (act == ACT_REMOVE) begin
      hit = 1'b0;
      for (i = 0; i < held_count && !hit; i++) begin
        if (held[i].vertex == vid) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (hit) begin
        for (i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
        held_count--;
      end
    end
    if (held_count == 0) begin
      rpt.is_empty = 1'b1;
    end else begin
      rpt.vertex = held[0].vertex;
      rpt.key    = held[0].key;
    end
    rpt.count = held_count[CNT_BITS-1:0];
    return rpt;
  endfunction

  task automatic flag_bad(input string why, input head_report_t want);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%0t %s: want vtx=%h key=%0d empty=%b drop=%b cnt=%0d",
               $realtime, why, want.vertex, want.key, want.is_empty, want.dropped,
               want.count);
      $display("%0t %s:  got vtx=%h key=%0d empty=%b drop=%b cnt=%0d",
               $realtime, why, out_min_vertex, out_min_key, out_is_empty,
               out_dropped, out_entry_count);
    end
  endtask

  always @(posedge clk) begin
    head_report_t want;
    if (!rst_n) begin
      held_count = 0;
      head_reports_q.delete();
    end else begin
      // Retire the result word before queuing the one taken at this edge.
      if (out_valid && out_ready) begin
        if (head_reports_q.size() == 0) begin
          flag_bad("unexpected word", '0);
        end else begin
          want = head_reports_q.pop_front();
          if (out_min_vertex !== want.vertex || out_min_key !== want.key ||
              out_is_empty !== want.is_empty || out_dropped !== want.dropped ||
              out_entry_count !== want.count) begin
            flag_bad("mismatch", want);
          end
        end
      end
      if (in_valid && in_ready) begin
        head_reports_q.push_back(queue_apply(in_action, in_vertex_id, in_key));
      end
    end
    outstanding <= head_reports_q.size();
  end

endmodule

/* tb/sv/sorted_priority_queue_test.sv */
// Top of the sorted priority queue testbench: clock, reset, word stimulus
// with random idling on both sides and the verdict. Depends on spq_pkg,
// sorted_priority_queue and sorted_priority_queue_check.
`timescale 1ns / 100ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_action = ACT_PEEK;
  logic [ID_BITS-1:0]         in_vertex_id = '0;
  logic signed [KEY_BITS-1:0] in_key = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ID_BITS-1:0]         out_min_vertex;
  logic signed [KEY_BITS-1:0] out_min_key;
  logic                       out_is_empty;
  logic                       out_dropped;
  logic [CNT_BITS-1:0]        out_entry_count;
  int                         outstanding;
  int                         fail_count;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_rx = 1'b0;

  sorted_priority_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_id    (in_vertex_id),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_vertex  (out_min_vertex),
    .out_min_key     (out_min_key),
    .out_is_empty    (out_is_empty),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count)
  );

  sorted_priority_queue_check i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_id    (in_vertex_id),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_vertex  (out_min_vertex),
    .out_min_key     (out_min_key),
    .out_is_empty    (out_is_empty),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count),
    .outstanding     (outstanding),
    .fail_count      (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("sorted_priority_queue_test: done, errors");
    $finish;
  end

  // Long receiver hold-off; the sender keeps offering so the block backs up.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Receiver: draw a stall per word, then hold ready until the word is taken.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0 || hold_rx) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [ID_BITS-1:0] vid,
                           input logic [KEY_BITS-1:0] key);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_vertex_id <= vid;
    in_key       <= key;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Hold the sender until every predicted word has come back or the guard runs out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 5000);
  endtask

  function automatic logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_BITS-1:0] draw_vertex();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 3) != 0) return ID_BITS'($urandom_range(0, 15));
    return r[ID_BITS-1:0];
  endfunction

  function automatic logic [1:0] draw_action(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == MODE_FILL) begin
      if (roll < 85) return ACT_INSERT;
      if (roll < 95) return ACT_REMOVE;
      if (roll < 98) return ACT_PEEK;
      return ACT_SPARE;
    end else if (mode == MODE_DRAIN) begin
      if (roll < 10) return ACT_INSERT;
      if (roll < 90) return ACT_REMOVE;
      if (roll < 97) return ACT_PEEK;
      return ACT_SPARE;
    end
    if (roll < 40) return ACT_INSERT;
    if (roll < 80) return ACT_REMOVE;
    if (roll < 95) return ACT_PEEK;
    return ACT_SPARE;
  endfunction

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, key extremes, ties, duplicate vertices, misses.
    send_word(ACT_PEEK,   16'd0,     32'd0);
    send_word(ACT_REMOVE, 16'd5,     32'd0);
    send_word(ACT_SPARE,  16'd0,     32'd0);
    send_word(ACT_INSERT, 16'd0,     32'd0);
    send_word(ACT_INSERT, 16'hffff,  32'h7fff_ffff);
    send_word(ACT_INSERT, 16'd1,     32'h8000_0000);
    send_word(ACT_INSERT, 16'd2,     32'h8000_0000);
    send_word(ACT_INSERT, 16'd3,     32'hffff_ffff);
    send_word(ACT_INSERT, 16'd4,     32'd0);
    send_word(ACT_INSERT, 16'd1,     32'd5);
    send_word(ACT_REMOVE, 16'd1,     32'd0);
    send_word(ACT_REMOVE, 16'd1,     32'd0);
    send_word(ACT_REMOVE, 16'd999,   32'd0);
    send_word(ACT_PEEK,   16'd0,     32'd0);
    send_word(ACT_SPARE,  16'hffff,  32'hffff_ffff);
    send_word(ACT_INSERT, 16'haaaa,  32'h5555_5555);
    send_word(ACT_INSERT, 16'h5555,  32'haaaa_aaaa);
    send_word(ACT_REMOVE, 16'hffff,  32'd0);
    send_word(ACT_REMOVE, 16'd0,     32'd0);
    send_word(ACT_REMOVE, 16'd2,     32'd0);
    send_word(ACT_REMOVE, 16'd3,     32'd0);
    send_word(ACT_REMOVE, 16'd4,     32'd0);
    send_word(ACT_REMOVE, 16'haaaa,  32'd0);
    send_word(ACT_REMOVE, 16'h5555,  32'd0);

    // Insert burst past full under a long receiver hold-off.
    tx_idle  = 1'b0;
    rx_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (72) send_word(ACT_INSERT, draw_vertex(), draw_key());
    in_valid <= 1'b0;
    wait_drained();

    // Random segments with their own mix of actions and idling.
    for (int seg = 0; seg < 10; seg++) begin
      mode    = $urandom_range(0, 2);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat (36) send_word(draw_action(mode), draw_vertex(), draw_key());
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_priority_queue_test: done, clean");
    end else begin
      $display("sorted_priority_queue_test: done, errors");
    end
    $finish;
  end

endmodule
